@@ sv/oets_pkg.sv @@
// Shared types and constants for the odd-even transposition sorter.
package oets_pkg;

  localparam int KEY_W = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } oets_state_t;

  // Per-cell commands, decoded once per cycle by the sequencer.
  typedef struct packed {
    logic load;
    logic cmp_lo;
    logic cmp_hi;
    logic shift;
  } cell_ctl_t;

endpackage

@@ sv/odd_even_transposition_sorter.sv @@
// Top level of the odd-even transposition sorter: sequencer and row of cells.
//
// Keys arrive on the in_ channel, one word per key; in_last closes the list.
// Each key is written straight into the next free cell, one key per cycle.
// Up to MAX_LEN keys are kept; further keys are dropped and the whole list
// is then reported with out_overflow set on every result word.
// After the closing word the row runs N compare-exchange phases, where N is
// the number of stored keys; all pairs of a phase work in parallel. The sorted
// keys then leave on the out_ channel in ascending order, one per cycle while
// out_stall is low, by shifting the row toward cell 0; out_final_res marks the
// greatest key.
// in_stall is high from the closing word until the last result is taken.
// While out_stall is high the current result holds and the row does not move.
// A synchronous reset returns the block to the loading state with an empty
// list; stored keys are not cleared, they are simply overwritten.
module odd_even_transposition_sorter import oets_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [KEY_W-1:0] out_sorted_key,
  output logic                    out_final_res,
  output logic                    out_overflow
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_LEN);

  oets_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0] emit_r, emit_nxt;
  logic             dropped_r, dropped_nxt;

  logic in_acc;
  logic out_acc;
  logic last_out;
  logic last_phase;

  logic signed [KEY_W-1:0] cell_key [MAX_LEN];
  cell_ctl_t               cell_ctl [MAX_LEN];

  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;
  assign last_out   = (emit_r == count_r - CNT_W'(1));
  assign last_phase = (phase_r == count_r - CNT_W'(1));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (in_acc && in_last) state_nxt = ST_SORT;
      ST_SORT: if (last_phase) state_nxt = ST_EMIT;
      ST_EMIT: if (out_acc && last_out) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Counters and flags.
  always_comb begin
    count_nxt   = count_r;
    phase_nxt   = phase_r;
    emit_nxt    = emit_r;
    dropped_nxt = dropped_r;
    case (state_r)
      ST_LOAD: begin
        phase_nxt = '0;
        emit_nxt  = '0;
        if (in_acc) begin
          if (count_r < CAP) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
        end
      end
      ST_SORT: begin
        phase_nxt = phase_r + CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_acc) begin
          emit_nxt = emit_r + CNT_W'(1);
          if (last_out) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        count_nxt   = '0;
        dropped_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      phase_r   <= '0;
      emit_r    <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      phase_r   <= phase_nxt;
      emit_r    <= emit_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Output decode.
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_LOAD: in_stall  = 1'b0;
      ST_SORT: in_stall  = 1'b1;
      ST_EMIT: out_valid = 1'b1;
      default: in_stall  = 1'b1;
    endcase
  end

  assign out_sorted_key = cell_key[0];
  assign out_final_res  = last_out;
  assign out_overflow   = dropped_r;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);
    localparam logic [CNT_W-1:0] IDX1 = CNT_W'(i + 1);

    logic signed [KEY_W-1:0] left_key;
    logic signed [KEY_W-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = cell_key[i];
    end else begin : g_left
      assign left_key = cell_key[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_end
      assign right_key = cell_key[i];
    end else begin : g_right
      assign right_key = cell_key[i+1];
    end

    // Even phases pair each even cell with the one above it, odd phases
    // each odd cell; only pairs fully inside the list take part.
    always_comb begin
      cell_ctl[i].load   = (state_r == ST_LOAD) && in_acc && (count_r == IDX);
      cell_ctl[i].cmp_lo = (state_r == ST_SORT) && (IDX[0] == phase_r[0]) &&
                           (IDX1 < count_r);
      cell_ctl[i].cmp_hi = (state_r == ST_SORT) && (IDX[0] != phase_r[0]) &&
                           (i != 0) && (IDX < count_r);
      cell_ctl[i].shift  = out_acc;
    end

    oets_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .load_key  (in_key),
      .left_key  (left_key),
      .right_key (right_key),
      .key_o     (cell_key[i])
    );
  end

endmodule

@@ sv/oets_cell.sv @@
// One cell of the sorting row: holds one key and trades it with its neighbors.
module oets_cell import oets_pkg::*; (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [KEY_W-1:0] load_key,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic signed [KEY_W-1:0] right_key,
  output logic signed [KEY_W-1:0] key_o
);

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;

  // The lower cell of a pair keeps the smaller key, the upper cell the larger.
  always_comb begin
    key_nxt = key_r;
    if (ctl.load) begin
      key_nxt = load_key;
    end else if (ctl.shift) begin
      key_nxt = right_key;
    end else if (ctl.cmp_lo && (key_r > right_key)) begin
      key_nxt = right_key;
    end else if (ctl.cmp_hi && (left_key > key_r)) begin
      key_nxt = left_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o = key_r;

endmodule
